// ===== rtl/core/rlpg_pkg.sv =====
// Shared types and constants of the RGB LED pattern generator.
package rlpg_pkg;

  localparam int unsigned PERIOD_W       = 16;
  localparam int unsigned COLOR_W        = 24;
  localparam int unsigned BRIGHT_W       = 12;
  localparam int unsigned LEVEL_W        = 8;
  localparam int unsigned IN_DATA_W      = 8;
  localparam int unsigned OUT_DATA_W     = 3 * LEVEL_W;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = 24;
  localparam int unsigned STEP_W         = 4;
  localparam int unsigned SRCH_W         = 7;
  localparam int unsigned THR_N          = 1 << SRCH_W;
  localparam int unsigned PCT_MAX        = 100;
  localparam int unsigned SINE_STEPS_DEF = 1024;

  localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd1000;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RST = 12'd2048;

  localparam logic [8:0] HUE_FULL  = 9'd360;
  localparam logic [9:0] HUE_RISE  = 10'd60;
  localparam logic [9:0] HUE_TOP   = 10'd180;
  localparam logic [9:0] HUE_END   = 10'd240;
  localparam logic [4:0] RAMP_MUL  = 5'd17;
  localparam logic [LEVEL_W-1:0] DIG_THRESH = 8'd127;

  // floor(x / 100) = (x * RECIP_100) >> SH_100 for x < 2^15
  localparam int unsigned SH_100    = 22;
  localparam logic [15:0] RECIP_100 = 16'(((64'd1 << SH_100) + 64'd99) / 64'd100);
  // floor(x / 4095) = (x * RECIP_4095) >> SH_4095 for x < 2^20
  localparam int unsigned SH_4095    = 32;
  localparam logic [20:0] RECIP_4095 = 21'(((64'd1 << SH_4095) + 64'd4094) / 64'd4095);

  typedef enum logic [1:0] {
    PAT_SOLID   = 2'd0,
    PAT_BLINK   = 2'd1,
    PAT_PULSE   = 2'd2,
    PAT_RAINBOW = 2'd3
  } pat_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_PERIOD = 3'd1,
    REG_COLOR  = 3'd2,
    REG_BRIGHT = 3'd3,
    REG_PWM    = 3'd4,
    REG_OFF    = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_START = 4'd1,
    CMD_MUL   = 4'd2,
    CMD_DIV   = 4'd3,
    CMD_FOLD  = 4'd4,
    CMD_SRCH  = 4'd5,
    CMD_COL   = 4'd6,
    CMD_D100  = 4'd7,
    CMD_BRT   = 4'd8,
    CMD_D4K   = 4'd9,
    CMD_LVL   = 4'd10,
    CMD_PUSH  = 4'd11
  } cmd_e;

  typedef struct packed {
    pat_e                  mode;
    logic [PERIOD_W-1:0]   period;
    logic [COLOR_W-1:0]    color;
    logic [BRIGHT_W-1:0]   bright;
    logic                  use_pwm;
    logic [LEVEL_W-1:0]    off;
  } cfg_t;

  typedef struct packed {
    cmd_e              op;
    logic [STEP_W-1:0] step;
    logic [1:0]        ch;
  } cmd_t;

  typedef struct packed {
    logic out_full;
  } sts_t;

endpackage

// ===== rtl/core/rlpg_cfg.sv =====
// Configuration register file of the RGB LED pattern generator.
module rlpg_cfg import rlpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_MODE:   cfg_d.mode    = pat_e'(cfg_wdata_i[1:0]);
        REG_PERIOD: cfg_d.period  = cfg_wdata_i[PERIOD_W-1:0];
        REG_COLOR:  cfg_d.color   = cfg_wdata_i[COLOR_W-1:0];
        REG_BRIGHT: cfg_d.bright  = cfg_wdata_i[BRIGHT_W-1:0];
        REG_PWM:    cfg_d.use_pwm = cfg_wdata_i[0];
        REG_OFF:    cfg_d.off     = cfg_wdata_i[LEVEL_W-1:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode    <= PAT_SOLID;
      cfg_q.period  <= PERIOD_RST;
      cfg_q.color   <= '0;
      cfg_q.bright  <= BRIGHT_RST;
      cfg_q.use_pwm <= 1'b1;
      cfg_q.off     <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/rlpg_ctrl.sv =====
// Sequencing state machine of the RGB LED pattern generator.
module rlpg_ctrl import rlpg_pkg::*; #(
  parameter int unsigned SINE_STEPS = SINE_STEPS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam int unsigned MAX_MULT = (SINE_STEPS > 360) ? SINE_STEPS : 360;
  localparam int unsigned QW       = $clog2(MAX_MULT + 1);
  localparam logic [1:0]  CH_LAST  = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_MUL  = 11'b00000000010,
    S_DIV  = 11'b00000000100,
    S_FOLD = 11'b00000001000,
    S_SRCH = 11'b00000010000,
    S_COL  = 11'b00000100000,
    S_D100 = 11'b00001000000,
    S_BRT  = 11'b00010000000,
    S_D4K  = 11'b00100000000,
    S_LVL  = 11'b01000000000,
    S_DONE = 11'b10000000000
  } state_e;

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [1:0]        ch_q, ch_d;

  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    ch_d       = ch_q;
    in_ready_o = 1'b0;
    cmd_o      = '{op: CMD_NONE, step: step_q, ch: ch_q};
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_START;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = CMD_MUL;
        step_d   = STEP_W'(QW - 1);
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = CMD_DIV;
        if (step_q == '0) begin
          state_d = S_FOLD;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_FOLD: begin
        cmd_o.op = CMD_FOLD;
        step_d   = STEP_W'(SRCH_W - 1);
        state_d  = S_SRCH;
      end
      S_SRCH: begin
        cmd_o.op = CMD_SRCH;
        if (step_q == '0) begin
          ch_d    = '0;
          state_d = S_COL;
        end else begin
          step_d = step_q - 1'b1;
        end
      end
      S_COL: begin
        cmd_o.op = CMD_COL;
        state_d  = S_D100;
      end
      S_D100: begin
        cmd_o.op = CMD_D100;
        state_d  = S_BRT;
      end
      S_BRT: begin
        cmd_o.op = CMD_BRT;
        state_d  = S_D4K;
      end
      S_D4K: begin
        cmd_o.op = CMD_D4K;
        state_d  = S_LVL;
      end
      S_LVL: begin
        cmd_o.op = CMD_LVL;
        if (ch_q == CH_LAST) begin
          state_d = S_DONE;
        end else begin
          ch_d    = ch_q + 1'b1;
          state_d = S_COL;
        end
      end
      S_DONE: begin
        if (!sts_i.out_full) begin
          cmd_o.op = CMD_PUSH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      ch_q    <= ch_d;
    end
  end

endmodule

// ===== rtl/core/rlpg_dp.sv =====
// Datapath of the RGB LED pattern generator: counter, divider, sine search, levels.
module rlpg_dp import rlpg_pkg::*; #(
  parameter int unsigned SINE_STEPS = SINE_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  cmd_t                  cmd_i,
  input  logic                  restart_i,
  output sts_t                  sts_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned MAX_MULT = (SINE_STEPS > 360) ? SINE_STEPS : 360;
  localparam int unsigned QW       = $clog2(MAX_MULT + 1);
  localparam int unsigned NW       = PERIOD_W + QW;
  localparam int unsigned KW       = $clog2(SINE_STEPS);
  localparam int unsigned QFW      = KW + 3;
  localparam int unsigned QTR      = SINE_STEPS / 2;
  localparam int unsigned JW       = $clog2(QTR + 2);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_ONE     = 64'd1 << 30;
  localparam longint unsigned PCT_BIAS    = 64'd1 << 16;

  // sine magnitude in percent at quarter-turn position 2*j/SINE_STEPS
  function automatic int unsigned sine_mag(int unsigned j);
    longint unsigned th;
    longint unsigned th2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    th   = (HALF_PI_Q30 * (64'(j) * 64'd2)) / SINE_STEPS;
    th2  = (th * th) >> 30;
    sum  = $signed(th);
    term = th;
    term = ((term * th2) >> 30) / 6;
    sum  = sum - $signed(term);
    term = ((term * th2) >> 30) / 20;
    sum  = sum + $signed(term);
    term = ((term * th2) >> 30) / 42;
    sum  = sum - $signed(term);
    term = ((term * th2) >> 30) / 72;
    sum  = sum + $signed(term);
    term = ((term * th2) >> 30) / 110;
    sum  = sum - $signed(term);
    term = ((term * th2) >> 30) / 156;
    sum  = sum + $signed(term);
    if (sum < 0) sum = 0;
    if (sum > $signed(Q30_ONE)) sum = $signed(Q30_ONE);
    mag = ($unsigned(sum) * 64'd100 + PCT_BIAS) >> 30;
    if (mag > 64'(PCT_MAX)) mag = 64'(PCT_MAX);
    return 32'(mag);
  endfunction

  // smallest quarter index whose magnitude reaches m
  function automatic int unsigned thr_of(int unsigned m);
    int unsigned res;
    int unsigned jj;
    logic        found;
    res   = QTR + 1;
    found = 1'b0;
    if (m <= PCT_MAX) begin
      for (jj = 0; jj <= QTR; jj++) begin
        if (!found && sine_mag(jj) >= m) begin
          res   = jj;
          found = 1'b1;
        end
      end
    end
    return res;
  endfunction

  function automatic logic [8:0] hue_start(logic [1:0] ch);
    case (ch)
      2'd0:    return 9'd240;
      2'd1:    return 9'd0;
      default: return 9'd120;
    endcase
  endfunction

  logic [JW-1:0] thr_w [THR_N];
  for (genvar g = 0; g < THR_N; g++) begin : g_thr
    assign thr_w[g] = JW'(thr_of(g));
  end

  logic [PERIOD_W-1:0] elapsed_q, elapsed_d;
  logic [PERIOD_W-1:0] t_q, t_d;
  pat_e                mode_q, mode_d;
  logic                on_q, on_d;
  logic [NW-1:0]       rem_q, rem_d;
  logic [QW-1:0]       quot_q, quot_d;
  logic [JW-1:0]       j_q, j_d;
  logic                neg_q, neg_d;
  logic [SRCH_W-1:0]   lo_q, lo_d;
  logic [14:0]         prod_q, prod_d;
  logic [LEVEL_W-1:0]  col_q, col_d;
  logic                cneg_q, cneg_d;
  logic [19:0]         x_q, x_d;
  logic [LEVEL_W-1:0]  sc_q, sc_d;
  logic [LEVEL_W-1:0]  lvl_q [3];
  logic [LEVEL_W-1:0]  lvl_d [3];
  logic [OUT_DATA_W-1:0] out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic [PERIOD_W-1:0] p_eff;
  logic [PERIOD_W:0]   t_inc;
  logic [PERIOD_W-1:0] t_next;
  pat_e                mode_eff;
  logic [QW-1:0]       mult;
  logic [NW-1:0]       num;
  logic [NW-1:0]       trial;
  logic [KW-1:0]       k;
  logic [QFW-1:0]      q0, q1, q2;
  logic                fold_neg;
  logic [SRCH_W-1:0]   cand;
  logic [LEVEL_W-1:0]  base;
  logic [8:0]          hue_a;
  logic [8:0]          hs;
  logic [9:0]          d;
  logic [14:0]         ramp;
  logic [LEVEL_W-1:0]  rb_col;
  logic [30:0]         p100;
  logic [40:0]         p4k;
  logic [LEVEL_W:0]    sum9;
  logic [LEVEL_W-1:0]  lvl;

  always_comb begin
    p_eff  = (cfg_i.period == '0) ? PERIOD_W'(1) : cfg_i.period;
    t_inc  = {1'b0, elapsed_q} + 1'b1;
    if (restart_i || (t_inc > {1'b0, p_eff})) begin
      t_next = '0;
    end else begin
      t_next = t_inc[PERIOD_W-1:0];
    end
    mode_eff = (cfg_i.mode == PAT_PULSE && !cfg_i.use_pwm) ? PAT_BLINK : cfg_i.mode;

    mult  = (mode_q == PAT_PULSE) ? QW'(SINE_STEPS) : QW'(HUE_FULL);
    num   = {{QW{1'b0}}, t_q} * {{PERIOD_W{1'b0}}, mult};
    trial = {{QW{1'b0}}, p_eff} << cmd_i.step;

    k        = (quot_q == QW'(SINE_STEPS)) ? '0 : quot_q[KW-1:0];
    q0       = {1'b0, k, 2'b00};
    fold_neg = q0 >= QFW'(2 * SINE_STEPS);
    q1       = fold_neg ? q0 - QFW'(2 * SINE_STEPS) : q0;
    q2       = (q1 > QFW'(SINE_STEPS)) ? QFW'(2 * SINE_STEPS) - q1 : q1;

    cand = lo_q | (SRCH_W'(1) << cmd_i.step);

    case (cmd_i.ch)
      2'd0:    base = cfg_i.color[23:16];
      2'd1:    base = cfg_i.color[15:8];
      default: base = cfg_i.color[7:0];
    endcase

    hue_a = quot_q[8:0];
    hs    = hue_start(cmd_i.ch);
    if (hue_a < hs) begin
      d = {1'b0, hue_a} + {1'b0, HUE_FULL} - {1'b0, hs};
    end else begin
      d = {1'b0, hue_a} - {1'b0, hs};
    end
    if (d < HUE_RISE) begin
      ramp   = {5'd0, d} * {10'd0, RAMP_MUL};
      rb_col = ramp[LEVEL_W+1:2];
    end else if (d < HUE_TOP) begin
      ramp   = '0;
      rb_col = '1;
    end else if (d < HUE_END) begin
      ramp   = {5'd0, HUE_END - d} * {10'd0, RAMP_MUL};
      rb_col = ramp[LEVEL_W+1:2];
    end else begin
      ramp   = '0;
      rb_col = '0;
    end

    p100 = {16'd0, prod_q} * {15'd0, RECIP_100};
    p4k  = {21'd0, x_q} * {20'd0, RECIP_4095};

    sum9 = {1'b0, cfg_i.off} + {1'b0, sc_q};
    if (cfg_i.use_pwm) begin
      if (cneg_q) begin
        lvl = sum9[LEVEL_W] ? '1 : sum9[LEVEL_W-1:0];
      end else if (cfg_i.off >= sc_q) begin
        lvl = cfg_i.off - sc_q;
      end else begin
        lvl = sc_q - cfg_i.off;
      end
    end else if (cfg_i.off == '0) begin
      lvl = LEVEL_W'(col_q >= DIG_THRESH);
    end else begin
      lvl = LEVEL_W'(col_q < DIG_THRESH);
    end
  end

  always_comb begin
    elapsed_d   = elapsed_q;
    t_d         = t_q;
    mode_d      = mode_q;
    on_d        = on_q;
    rem_d       = rem_q;
    quot_d      = quot_q;
    j_d         = j_q;
    neg_d       = neg_q;
    lo_d        = lo_q;
    prod_d      = prod_q;
    col_d       = col_q;
    cneg_d      = cneg_q;
    x_d         = x_q;
    sc_d        = sc_q;
    lvl_d       = lvl_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (cmd_i.op)
      CMD_START: begin
        elapsed_d = t_next;
        t_d       = t_next;
        mode_d    = mode_eff;
        on_d      = t_next < (p_eff >> 1);
      end
      CMD_MUL: begin
        rem_d  = num;
        quot_d = '0;
      end
      CMD_DIV: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          quot_d = quot_q | (QW'(1) << cmd_i.step);
        end
      end
      CMD_FOLD: begin
        j_d   = q2[JW:1];
        neg_d = fold_neg;
        lo_d  = '0;
      end
      CMD_SRCH: begin
        if (thr_w[cand] <= j_q) lo_d = cand;
      end
      CMD_COL: begin
        prod_d = {1'b0, lo_q} * {7'd0, base};
        cneg_d = 1'b0;
        case (mode_q)
          PAT_SOLID:   col_d = base;
          PAT_BLINK:   col_d = on_q ? base : '0;
          PAT_PULSE: begin
            col_d  = '0;
            cneg_d = neg_q;
          end
          default:     col_d = rb_col;
        endcase
      end
      CMD_D100: begin
        if (mode_q == PAT_PULSE) col_d = p100[SH_100+LEVEL_W-1:SH_100];
      end
      CMD_BRT: begin
        x_d = {12'd0, col_q} * {8'd0, cfg_i.bright};
      end
      CMD_D4K: begin
        sc_d = p4k[SH_4095+LEVEL_W-1:SH_4095];
      end
      CMD_LVL: begin
        case (cmd_i.ch)
          2'd0:    lvl_d[0] = lvl;
          2'd1:    lvl_d[1] = lvl;
          default: lvl_d[2] = lvl;
        endcase
      end
      CMD_PUSH: begin
        out_d       = {lvl_q[2], lvl_q[1], lvl_q[0]};
        out_valid_d = 1'b1;
      end
      default: out_d = out_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elapsed_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      elapsed_q   <= elapsed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    mode_q <= mode_d;
    on_q   <= on_d;
    rem_q  <= rem_d;
    quot_q <= quot_d;
    j_q    <= j_d;
    neg_q  <= neg_d;
    lo_q   <= lo_d;
    prod_q <= prod_d;
    col_q  <= col_d;
    cneg_q <= cneg_d;
    x_q    <= x_d;
    sc_q   <= sc_d;
    lvl_q  <= lvl_d;
    out_q  <= out_d;
  end

  assign sts_o.out_full = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== rtl/core/rgb_led_pattern_generator.sv =====
// Top level of the RGB LED pattern generator.
//
//   channel   direction  payload
//   s_axis    in         tdata[0] restart, one tick per word
//   m_axis    out        tdata red/green/blue levels, one word per tick
//   cfg       in         write enable, register index, write data
//
// Each tick runs through the one-bit-per-cycle period divider, the seven-step
// sine search and four shared multiply steps per colour channel.
// Reset clears the elapsed counter and loads the register defaults.
// A finished word waits in the output register; the next tick is taken meanwhile,
// and its result is held until the output register is free.
module rgb_led_pattern_generator import rlpg_pkg::*; #(
  parameter int unsigned SINE_STEPS = SINE_STEPS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [0] restart
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  rlpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  rlpg_ctrl #(
    .SINE_STEPS (SINE_STEPS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  rlpg_dp #(
    .SINE_STEPS (SINE_STEPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd),
    .restart_i   (s_axis_tdata[0]),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
